[rtl/detection_report_deframer_top_macros.svh]
// Assertion macros shared by the deframer modules.
`ifndef DETECTION_REPORT_DEFRAMER_TOP_MACROS_SVH
`define DETECTION_REPORT_DEFRAMER_TOP_MACROS_SVH

// Check that a condition implies a consequence on the same edge.
`define DRD_ASSERT_IMPL(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed");

// Check that a condition implies a consequence on the next edge.
`define DRD_ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/drd_pkg.sv]
package drd_pkg;

  localparam int TableDepth = 64;

  localparam logic [1:0] KindReport = 2'b00;
  localparam logic [1:0] KindStatus = 2'b01;
  localparam logic [7:0] ProtoSensor = 8'd255;

  typedef enum logic [5:0] {
    ST_HDR    = 6'b000001,
    ST_SEARCH = 6'b000010,
    ST_FRAME  = 6'b000100,
    ST_STATUS = 6'b001000,
    ST_STORE  = 6'b010000,
    ST_SKIP   = 6'b100000
  } state_t;

  // Frame length for a protocol byte, 0 for an unknown protocol.
  function automatic logic [3:0] frame_len(input logic [7:0] p);
    logic [3:0] n;
    if (p == ProtoSensor) n = 4'd8;
    else if (p == 8'd0) n = 4'd5;
    else if (p <= 8'd3) n = 4'd6;
    else if (p <= 8'd7) n = 4'd7;
    else n = 4'd0;
    return n;
  endfunction

  // Request from the parser to the location table.
  typedef struct packed {
    logic        search;
    logic        store;
    logic [13:0] serial;
    logic [24:0] lat;
    logic [25:0] lon;
  } tbl_req_t;

  // Answer of the location table.
  typedef struct packed {
    logic        busy;
    logic        done;
    logic        hit;
    logic [24:0] lat;
    logic [25:0] lon;
  } tbl_rsp_t;

endpackage

[rtl/drd_table.sv]
module drd_table #(
  parameter int TABLE_DEPTH = drd_pkg::TableDepth
) (
  input  logic               clk,
  input  logic               rst,
  input  drd_pkg::tbl_req_t  req,
  output drd_pkg::tbl_rsp_t  rsp
);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] Full = CW'(TABLE_DEPTH);

  logic [13:0] mem_serial [TABLE_DEPTH];
  logic [50:0] mem_loc [TABLE_DEPTH];

  logic [CW-1:0] count;
  logic [CW-1:0] scan;
  logic          active;
  logic          is_store;
  logic          rd_valid;
  logic [AW-1:0] rd_addr;
  logic [13:0]   rd_serial;
  logic [50:0]   rd_loc;
  logic [13:0]   key;
  logic [50:0]   wloc;
  logic          done;
  logic          hit;
  logic [50:0]   hit_loc;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  assign rd_addr = scan[AW-1:0];

  always_ff @(posedge clk) begin
    rd_serial <= mem_serial[rd_addr];
    rd_loc <= mem_loc[rd_addr];
    if (wr_en) begin
      mem_serial[wr_addr] <= key;
      mem_loc[wr_addr] <= wloc;
    end
  end

  // Scan one entry a cycle; the read result is compared in the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      active <= 1'b0;
      rd_valid <= 1'b0;
      done <= 1'b0;
      hit <= 1'b0;
      scan <= '0;
      is_store <= 1'b0;
      wr_en <= 1'b0;
    end else begin
      done <= 1'b0;
      wr_en <= 1'b0;
      if (!active && (req.search || req.store)) begin
        active <= 1'b1;
        is_store <= req.store;
        key <= req.serial;
        wloc <= {req.lat, req.lon};
        scan <= '0;
        rd_valid <= 1'b0;
      end else if (active) begin
        if (rd_valid && rd_serial == key) begin
          active <= 1'b0;
          rd_valid <= 1'b0;
          done <= 1'b1;
          hit <= 1'b1;
          hit_loc <= rd_loc;
          if (is_store) begin
            wr_en <= 1'b1;
            wr_addr <= rd_addr - AW'(1);
          end
        end else if (scan >= count) begin
          active <= 1'b0;
          rd_valid <= 1'b0;
          done <= 1'b1;
          hit <= 1'b0;
          if (is_store && count != Full) begin
            wr_en <= 1'b1;
            wr_addr <= count[AW-1:0];
            count <= count + CW'(1);
          end
        end else begin
          rd_valid <= 1'b1;
          scan <= scan + CW'(1);
        end
      end
    end
  end

  assign rsp.busy = active || wr_en;
  assign rsp.done = done;
  assign rsp.hit = hit;
  assign rsp.lat = hit_loc[50:26];
  assign rsp.lon = hit_loc[25:0];

  `include "detection_report_deframer_top_macros.svh"
  `DRD_ASSERT_IMPL(a_count_range, clk, rst, 1'b1, count <= Full)
  `DRD_ASSERT_NEXT(a_done_ends, clk, rst, done, !done)
  `DRD_ASSERT_IMPL(a_wr_bound, clk, rst, wr_en, CW'(wr_addr) < count)
endmodule

[rtl/detection_report_deframer_top.sv]
// Detection report deframer. Takes one payload byte per item and gives one
// record per completed frame. Header and frame bytes are taken one per
// cycle. After the sixth byte of a report, or the ninth of a status, the
// location table is scanned one entry per cycle and input stalls while the
// scan runs; a status then writes its entry unless the table is full and
// lacks its serial. A finished record waits in an output register; no
// byte is taken while a record waits unless that record leaves in the same
// cycle.
module detection_report_deframer_top #(
  parameter int TABLE_DEPTH = drd_pkg::TableDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        record_kind,
  output logic [13:0] receiver_serial,
  output logic [31:0] event_time,
  output logic [24:0] position_lat,
  output logic [25:0] position_lon,
  output logic [15:0] value_a,
  output logic [15:0] value_b,
  output logic [7:0]  value_c,
  output logic [7:0]  value_d,
  output logic [9:0]  value_e
);
  drd_pkg::state_t state;
  drd_pkg::tbl_req_t req;
  drd_pkg::tbl_rsp_t rsp;

  logic [2:0]  hpos;
  logic [1:0]  kind;
  logic [13:0] serial;
  logic [31:0] base_time;
  logic [24:0] lat;
  logic [25:0] lon;
  logic [7:0]  fb [8];
  logic [3:0]  fidx;
  logic [3:0]  flen;
  logic        wait_tbl;
  logic        status_last;
  logic        take;
  logic        emit;
  logic [3:0]  fidx_next;
  logic [3:0]  flen_next;
  logic [7:0]  f [8];
  logic [7:0]  pa;
  logic [7:0]  pb;

  drd_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp)
  );

  // Frame view with the incoming byte in place.
  always_comb begin
    for (int i = 0; i < 8; i++) f[i] = fb[i];
    f[fidx[2:0]] = data_byte;
    fidx_next = fidx + 4'd1;
    flen_next = (fidx_next == 4'd2) ? drd_pkg::frame_len(data_byte) : flen;
    emit = (state == drd_pkg::ST_FRAME) && flen_next != 4'd0 && fidx_next == flen_next;
    pa = f[3'(flen_next - 4'd2)];
    pb = f[3'(flen_next - 4'd1)];
  end

  // Hold input while a table access is pending or a record waits.
  assign in_ready = !wait_tbl && !rsp.busy && state != drd_pkg::ST_SEARCH &&
                    state != drd_pkg::ST_STORE && !(out_valid && !out_ready);
  assign take = in_valid && in_ready;

  always_comb begin
    req = '0;
    req.serial = serial;
    req.lat = lat;
    req.lon = lon;
    req.search = (state == drd_pkg::ST_SEARCH) && !wait_tbl && !rsp.busy;
    req.store = (state == drd_pkg::ST_STORE) && !wait_tbl && !rsp.busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= drd_pkg::ST_HDR;
      hpos <= '0;
      fidx <= '0;
      flen <= '0;
      wait_tbl <= 1'b0;
      out_valid <= 1'b0;
      status_last <= 1'b0;
    end else begin
      if (out_valid && out_ready && !(take && emit)) out_valid <= 1'b0;
      if (req.search || req.store) wait_tbl <= 1'b1;
      if (wait_tbl && rsp.done) begin
        wait_tbl <= 1'b0;
        if (state == drd_pkg::ST_SEARCH) begin
          lat <= rsp.hit ? rsp.lat : '0;
          lon <= rsp.hit ? rsp.lon : '0;
          state <= drd_pkg::ST_FRAME;
        end else begin
          state <= status_last ? drd_pkg::ST_HDR : drd_pkg::ST_SKIP;
        end
      end
      if (take) begin
        unique case (state)
          drd_pkg::ST_HDR: begin
            hpos <= hpos + 3'd1;
            if (hpos == 3'd0) serial <= {data_byte, 6'd0};
            else if (hpos == 3'd1) begin
              serial[5:0] <= data_byte[7:2];
              kind <= data_byte[1:0];
            end else base_time <= {base_time[23:0], data_byte};
            fidx <= '0;
            flen <= '0;
            if (hpos == 3'd5 && !last_byte) begin
              if (kind == drd_pkg::KindReport) state <= drd_pkg::ST_SEARCH;
              else if (kind == drd_pkg::KindStatus) begin
                lon <= {drd_pkg::KindStatus, base_time[23:0]};
                lat <= {24'd0, data_byte[0]};
                hpos <= '0;
                state <= drd_pkg::ST_STATUS;
              end else state <= drd_pkg::ST_SKIP;
            end
          end
          drd_pkg::ST_FRAME: begin
            fb[fidx[2:0]] <= data_byte;
            fidx <= fidx_next;
            flen <= flen_next;
            if (fidx_next == 4'd2 && flen_next == 4'd0) state <= drd_pkg::ST_SKIP;
            if (emit) begin
              fidx <= '0;
              flen <= '0;
              out_valid <= 1'b1;
              receiver_serial <= serial;
              event_time <= base_time + {24'd0, f[0]};
              if (flen_next == 4'd8) begin
                record_kind <= 1'b0;
                position_lat <= '0;
                position_lon <= '0;
                value_a <= {f[2], f[3]};
                value_b <= {8'd0, f[4]};
                value_c <= f[5];
                value_d <= f[6];
                value_e <= {2'd0, f[7]};
              end else begin
                record_kind <= 1'b1;
                position_lat <= lat;
                position_lon <= lon;
                value_c <= f[1];
                value_d <= {2'd0, pa[7:2]};
                value_e <= {pa[1:0], pb};
                case (f[1][2:0])
                  3'd0: begin value_a <= {8'd0, f[2]}; value_b <= '0; end
                  3'd1, 3'd2: begin value_a <= {f[2], f[3]}; value_b <= '0; end
                  3'd3: begin value_a <= {8'd0, f[2]}; value_b <= {8'd0, f[3]}; end
                  3'd4, 3'd5: begin value_a <= {f[2], f[3]}; value_b <= {8'd0, f[4]}; end
                  default: begin value_a <= {8'd0, f[2]}; value_b <= {f[3], f[4]}; end
                endcase
              end
            end
          end
          drd_pkg::ST_STATUS: begin
            lat <= {lat[16:0], data_byte};
            hpos <= hpos + 3'd1;
            if (hpos == 3'd2) begin
              state <= drd_pkg::ST_STORE;
              status_last <= last_byte;
            end
          end
          drd_pkg::ST_SKIP: ;
          default: ;
        endcase
        if (last_byte) begin
          hpos <= '0;
          fidx <= '0;
          flen <= '0;
          if (!(state == drd_pkg::ST_STATUS && hpos == 3'd2)) state <= drd_pkg::ST_HDR;
        end
      end
    end
  end

  `include "detection_report_deframer_top_macros.svh"
  `DRD_ASSERT_IMPL(a_no_take_wait, clk, rst, wait_tbl, !in_ready)
  `DRD_ASSERT_IMPL(a_emit_room, clk, rst, take && emit, !out_valid || out_ready)
  `DRD_ASSERT_IMPL(a_fidx_bound, clk, rst, 1'b1, fidx <= 4'd8)
endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;

  localparam int TableSlots = drd_pkg::TableDepth;

  typedef struct packed {
    logic        kind;
    logic [13:0] serial;
    logic [31:0] etime;
    logic [24:0] lat;
    logic [25:0] lon;
    logic [15:0] a;
    logic [15:0] b;
    logic [7:0]  c;
    logic [7:0]  d;
    logic [9:0]  e;
  } record_t;

  class record_scoreboard;
    record_t pending[$];
    int errors;
    // parser state
    int hdr_pos;
    logic [1:0] pkind;
    logic [13:0] serial;
    logic [31:0] btime;
    logic [24:0] lat;
    logic [25:0] lon;
    logic [7:0] fb[8];
    int fidx;
    int flen;
    bit stopped;
    logic [13:0] t_serial[TableSlots];
    logic [24:0] t_lat[TableSlots];
    logic [25:0] t_lon[TableSlots];
    int t_count;

    function int lookup(logic [13:0] s);
      for (int i = 0; i < t_count; i++) if (t_serial[i] == s) return i;
      return -1;
    endfunction

    function int proto_len(logic [7:0] p);
      if (p == drd_pkg::ProtoSensor) return 8;
      if (p == 8'd0) return 5;
      if (p <= 8'd3) return 6;
      if (p <= 8'd7) return 7;
      return 0;
    endfunction

    function void decode_frame();
      record_t r;
      logic [7:0] pe;
      r = '0;
      r.serial = serial;
      r.etime = btime + {24'd0, fb[0]};
      if (flen == 8) begin
        r.kind = 1'b0;
        r.a = {fb[2], fb[3]};
        r.b = {8'd0, fb[4]};
        r.c = fb[5];
        r.d = fb[6];
        r.e = {2'd0, fb[7]};
      end else begin
        r.kind = 1'b1;
        r.lat = lat;
        r.lon = lon;
        r.c = fb[1];
        case (fb[1])
          8'd0: r.a = {8'd0, fb[2]};
          8'd1, 8'd2: r.a = {fb[2], fb[3]};
          8'd3: begin
            r.a = {8'd0, fb[2]};
            r.b = {8'd0, fb[3]};
          end
          8'd4, 8'd5: begin
            r.a = {fb[2], fb[3]};
            r.b = {8'd0, fb[4]};
          end
          default: begin
            r.a = {8'd0, fb[2]};
            r.b = {fb[3], fb[4]};
          end
        endcase
        pe = fb[flen - 2];
        r.d = pe >> 2;
        r.e = {pe[1:0], fb[flen - 1]};
      end
      pending.push_back(r);
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      int slot;
      if (stopped) begin
      end else if (hdr_pos < 6) begin
        if (hdr_pos == 0) serial = {b, 6'd0};
        else if (hdr_pos == 1) begin
          serial[5:0] = b[7:2];
          pkind = b[1:0];
        end else btime = {btime[23:0], b};
        hdr_pos++;
        if (hdr_pos == 6) begin
          if (pkind == drd_pkg::KindReport) begin
            slot = lookup(serial);
            lat = (slot >= 0) ? t_lat[slot] : '0;
            lon = (slot >= 0) ? t_lon[slot] : '0;
            fidx = 0;
            flen = 0;
          end else if (pkind == drd_pkg::KindStatus) begin
            lon = {pkind, btime[31:8]};
            lat = {24'd0, b[0]};
          end else stopped = 1;
        end
      end else if (pkind == drd_pkg::KindStatus) begin
        if (hdr_pos < 9) begin
          lat = {lat[16:0], b};
          hdr_pos++;
          if (hdr_pos == 9) begin
            slot = lookup(serial);
            if (slot < 0 && t_count < TableSlots) begin
              slot = t_count;
              t_count++;
            end
            if (slot >= 0) begin
              t_serial[slot] = serial;
              t_lat[slot] = lat;
              t_lon[slot] = lon;
            end
          end
        end
      end else begin
        fb[fidx & 7] = b;
        fidx++;
        if (fidx == 2) begin
          flen = proto_len(b);
          if (flen == 0) stopped = 1;
        end
        if (!stopped && flen != 0 && fidx == flen) begin
          decode_frame();
          fidx = 0;
          flen = 0;
        end
      end
      if (last) begin
        hdr_pos = 0;
        fidx = 0;
        flen = 0;
        stopped = 0;
      end
    endfunction

    function void check_record(record_t got);
      record_t x;
      if (pending.size() == 0) begin
        $error("record with none expected");
        errors++;
        return;
      end
      x = pending.pop_front();
      if (got.kind !== x.kind) begin
        $error("record_kind exp %0h got %0h", x.kind, got.kind); errors++;
      end
      if (got.serial !== x.serial) begin
        $error("receiver_serial exp %0h got %0h", x.serial, got.serial); errors++;
      end
      if (got.etime !== x.etime) begin
        $error("event_time exp %0h got %0h", x.etime, got.etime); errors++;
      end
      if (got.lat !== x.lat) begin
        $error("position_lat exp %0h got %0h", x.lat, got.lat); errors++;
      end
      if (got.lon !== x.lon) begin
        $error("position_lon exp %0h got %0h", x.lon, got.lon); errors++;
      end
      if (got.a !== x.a) begin
        $error("value_a exp %0h got %0h", x.a, got.a); errors++;
      end
      if (got.b !== x.b) begin
        $error("value_b exp %0h got %0h", x.b, got.b); errors++;
      end
      if (got.c !== x.c) begin
        $error("value_c exp %0h got %0h", x.c, got.c); errors++;
      end
      if (got.d !== x.d) begin
        $error("value_d exp %0h got %0h", x.d, got.d); errors++;
      end
      if (got.e !== x.e) begin
        $error("value_e exp %0h got %0h", x.e, got.e); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [7:0] data_byte = '0;
  logic last_byte = 0;
  logic out_valid;
  logic out_ready = 0;
  logic        record_kind;
  logic [13:0] receiver_serial;
  logic [31:0] event_time;
  logic [24:0] position_lat;
  logic [25:0] position_lon;
  logic [15:0] value_a, value_b;
  logic [7:0]  value_c, value_d;
  logic [9:0]  value_e;

  record_scoreboard board = new();
  int burst_left = 0;
  int items_sent = 0;
  int stall_mode = 0;
  logic [7:0] pay[$];

  always #1 clk = ~clk;

  detection_report_deframer_top dut (.*);

  // receiver: stall pattern changes every so often
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        board.check_record({record_kind, receiver_serial, event_time, position_lat,
                            position_lon, value_a, value_b, value_c, value_d, value_e});
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 1) != 0);
        default: out_ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // valid drops only at the end of a burst; the next burst starts after an idle gap
  task automatic send_byte(logic [7:0] b, logic last);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid <= 1'b1;
    data_byte <= b;
    last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_byte(b, last);
    items_sent++;
    if (burst_left == 0) in_valid <= 1'b0;
  endtask

  task automatic send_payload();
    foreach (pay[i]) send_byte(pay[i], i == pay.size() - 1);
    pay.delete();
  endtask

  task automatic header(logic [13:0] s, logic [1:0] k, logic [31:0] t);
    pay.push_back(s[13:6]);
    pay.push_back({s[5:0], k});
    for (int i = 3; i >= 0; i--) pay.push_back(t[8 * i +: 8]);
  endtask

  task automatic status(logic [13:0] s, logic [25:0] lon, logic [24:0] lat, int extra);
    pay.push_back(s[13:6]);
    pay.push_back({s[5:0], drd_pkg::KindStatus});
    pay.push_back(lon[23:16]);
    pay.push_back(lon[15:8]);
    pay.push_back(lon[7:0]);
    pay.push_back({7'($urandom_range(0, 127)), lat[24]});
    pay.push_back(lat[23:16]);
    pay.push_back(lat[15:8]);
    pay.push_back(lat[7:0]);
    repeat (extra) pay.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_frame(logic [7:0] proto);
    int n;
    n = board.proto_len(proto);
    pay.push_back(8'($urandom_range(0, 255)));
    pay.push_back(proto);
    for (int i = 2; i < n; i++) pay.push_back(8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] rand_proto();
    int r;
    r = $urandom_range(0, 19);
    if (r < 3) return drd_pkg::ProtoSensor;
    if (r == 19) return 8'($urandom_range(8, 254));
    return 8'(r % 8);
  endfunction

  task automatic wait_drained();
    if (burst_left != 0) begin
      in_valid <= 1'b0;
      burst_left = 0;
    end
    while (board.pending.size() != 0) @(posedge clk);
    repeat (TableSlots + 10) @(posedge clk);
  endtask

  logic [13:0] known[$];

  initial begin
    logic [13:0] s;
    int nfr;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: report with unknown serial, all protocols, extremes
    header(14'h3FFF, drd_pkg::KindReport, 32'hFFFF_FFF0);
    for (int p = 0; p < 8; p++) add_frame(8'(p));
    add_frame(drd_pkg::ProtoSensor);
    send_payload();
    status(14'h3FFF, 26'h3FF_FFFF, 25'h1FF_FFFF, 2);
    send_payload();
    status(14'h0000, 26'h0, 25'h0, 0);
    send_payload();
    header(14'h3FFF, drd_pkg::KindReport, 32'h0);
    add_frame(8'd6);
    add_frame(8'd9);
    add_frame(8'd0);
    send_payload();
    // cut short frame, short payloads, other kinds
    header(14'h0, drd_pkg::KindReport, 32'h1234_5678);
    pay.push_back(8'h00);
    pay.push_back(8'd4);
    pay.push_back(8'h55);
    send_payload();
    for (int i = 1; i <= 7; i++) begin
      for (int j = 0; j < i; j++) pay.push_back(8'($urandom_range(0, 255)));
      send_payload();
    end
    header(14'h2AAA, 2'b10, 32'hA5A5_A5A5);
    add_frame(8'd0);
    send_payload();
    header(14'h1555, 2'b11, 32'h5A5A_5A5A);
    add_frame(8'd1);
    send_payload();
    wait_drained();
    known.push_back(14'h3FFF);
    known.push_back(14'h0);
    // random: mostly well-formed reports and statuses
    while (items_sent < 1300) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          s = (known.size() > 0 && $urandom_range(0, 2) == 0) ?
              known[$urandom_range(0, known.size() - 1)] : 14'($urandom);
          if (board.lookup(s) < 0) known.push_back(s);
          status(s, 26'($urandom), 25'($urandom), $urandom_range(0, 1) ? 0 : 3);
          send_payload();
        end
        2: begin
          repeat ($urandom_range(1, 12)) pay.push_back(8'($urandom_range(0, 255)));
          send_payload();
        end
        default: begin
          s = (known.size() > 0 && $urandom_range(0, 3) != 0) ?
              known[$urandom_range(0, known.size() - 1)] : 14'($urandom);
          header(s, drd_pkg::KindReport, $urandom);
          nfr = $urandom_range(0, 4);
          repeat (nfr) add_frame(rand_proto());
          if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 6))
            pay.push_back(8'($urandom_range(0, 255)));
          send_payload();
        end
      endcase
      // hold off until the output side is drained
      if ($urandom_range(0, 40) == 0) wait_drained();
    end
    wait_drained();
    if (board.errors == 0 && board.pending.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
